### rtl/core/gcdb_pkg.sv
// gcdb_pkg: shared constants, types, tables and fixed-point helpers for the
// great-circle distance and bearing core. no dependencies.
package gcdb_pkg;

    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int COORD_W     = 25;
    localparam int IN_TDATA_W  = 104;
    localparam int DIST_W      = 19;
    localparam int BRG_W       = 25;
    localparam int OUT_TDATA_W = 48;

    localparam int SQRT_STAGES = 32;
    localparam int VEC_IN_W    = 34;
    localparam int QUOT_W      = 19;
    localparam int TURN_SHIFT  = 30 - ANGLE_FRAC_BITS;

    // ceil(2^32 / 90), exact quotient for any 25-bit magnitude
    localparam logic [25:0] RECIP_90 = 26'd47721859;

    localparam logic [31:0] LAT_LIM  = 32'(90 << ANGLE_FRAC_BITS);
    localparam logic [31:0] LON_LIM  = 32'(180 << ANGLE_FRAC_BITS);
    localparam logic [31:0] FULL_DEG = 32'(360 << ANGLE_FRAC_BITS);

    localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
    localparam logic [30:0]        QUARTER_TURN = 31'h4000_0000;
    localparam logic signed [31:0] CORDIC_GAIN  = 32'sh26DD3B6A;
    localparam logic [28:0]        DIST_SCALE   = 29'd327927635;

    typedef logic [31:0]        turn_t;
    typedef logic signed [31:0] q30_t;
    typedef logic [31:0]        frac_tbl_t [90];

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000};

    // turn fraction of a remainder r < 90: round(r * 2^(30-F) / 90)
    function automatic frac_tbl_t build_frac_tbl();
        frac_tbl_t t;
        longint    n;
        for (int r = 0; r < 90; r++)
        begin
            n    = (longint'(r) << TURN_SHIFT) + 45;
            t[r] = 32'(n / 90);
        end
        return t;
    endfunction

    localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

    // q2.30 product with floor shift
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

endpackage

### rtl/core/gcdb_sincos.sv
// gcdb_sincos: pipelined rotation cordic, binary angle in, q2.30 sine/cosine out.
// depends on gcdb_pkg. the input angle, every iteration and the outputs are registered.
module gcdb_sincos #(
    parameter int STAGES = gcdb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  gcdb_pkg::turn_t     angle,
    output gcdb_pkg::q30_t      sin_val,
    output gcdb_pkg::q30_t      cos_val
);
    import gcdb_pkg::*;

    localparam int W = 34;

    logic signed [W-1:0] x_reg [STAGES+1];
    logic signed [W-1:0] y_reg [STAGES+1];
    logic signed [W-1:0] z_reg [STAGES+1];
    logic                flip_reg [STAGES+1];
    q30_t                sin_reg;
    q30_t                cos_reg;

    logic  flip_next;
    turn_t ang_next;

    // fold second and third quadrants onto the first and fourth
    always_comb
    begin
        flip_next = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
        ang_next  = flip_next ? angle + HALF_TURN : angle;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= W'(CORDIC_GAIN);
            y_reg[0]    <= '0;
            z_reg[0]    <= W'($signed(ang_next));
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [W-1:0] ATN = $signed({{(W-32){1'b0}}, ATAN_TURNS[i]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATN;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    logic signed [W-1:0] sin_next;
    logic signed [W-1:0] cos_next;

    always_comb
    begin
        sin_next = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        cos_next = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next[31:0];
            cos_reg <= cos_next[31:0];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### rtl/core/gcdb_atan2.sv
// gcdb_atan2: pipelined vectoring cordic, atan2(y, x) as a binary angle.
// depends on gcdb_pkg. the input vector and every iteration are registered; the result is combinational.
module gcdb_atan2 #(
    parameter int STAGES = gcdb_pkg::CORDIC_STAGES_DEF,
    parameter int IN_W   = gcdb_pkg::VEC_IN_W
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] y_in,
    input  logic signed [IN_W-1:0] x_in,
    output gcdb_pkg::turn_t        turns
);
    import gcdb_pkg::*;

    localparam int W = IN_W + 3;

    logic signed [W-1:0] x_reg [STAGES+1];
    logic signed [W-1:0] y_reg [STAGES+1];
    turn_t               z_reg [STAGES+1];
    logic                zero_reg [STAGES+1];

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;

    always_comb
    begin
        xs = W'(x_in);
        ys = W'(y_in);
    end

    // move a left-half vector to the right half, starting from half a turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[IN_W-1])
            begin
                x_reg[0] <= -xs;
                y_reg[0] <= -ys;
                z_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TURNS[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TURNS[i];
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    assign turns = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule

### rtl/core/great_circle_distance_bearing_core.sv
// great_circle_distance_bearing_core: haversine distance and initial bearing
// between two points. depends on gcdb_pkg, gcdb_sincos and gcdb_atan2.
//
// usage
//   s_axis carries one item per point pair: tdata holds from_lat, from_lon,
//   to_lat, to_lon (25-bit signed, degrees * 2^16) from the lowest bit up.
//   m_axis returns one item per input item, in order: tdata holds the
//   distance in km/16 and the bearing in degrees * 2^16, tuser the
//   coordinate error flag (both results zero when it is set).
//   the pipeline runs through front-end angle conversion, sine/cosine
//   cordic, haversine products, digit-by-digit square root, vectoring
//   cordic and output scaling, in that order.
//   throughput is one item per cycle; the whole pipeline advances together
//   whenever the output register is empty or being taken.
//   when m_axis_tready is low with a result waiting, every stage holds and
//   s_axis_tready drops; nothing is dropped or repeated.
//   reset clears the valid bits of all stages; data registers are not reset.
module great_circle_distance_bearing_core #(
    parameter int CORDIC_STAGES = gcdb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // from_lat, from_lon, to_lat, to_lon, zero pad
    input  logic [gcdb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // distance_sixteenth_km, bearing, zero pad
    output logic [gcdb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // coord_error
    output logic                                m_axis_tuser
);
    import gcdb_pkg::*;

    localparam int LAT = 2 * CORDIC_STAGES + 45;   // pipeline depth in stages

    // ---------------------------------------------------------------
    // stage control: one valid and one error bit per stage
    // ---------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic [LAT-1:0] err_reg;
    logic [LAT-1:0] err_next;
    logic           adv;
    logic           err_in;

    assign adv           = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], s_axis_tvalid};
    assign err_next = {err_reg[LAT-2:0], err_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg <= err_next;
        end
    end

    // ---------------------------------------------------------------
    // s1: magnitudes and range check
    // ---------------------------------------------------------------
    logic signed [COORD_W-1:0] coord [4];
    logic [COORD_W-1:0]        mag_next [4];
    logic [COORD_W-1:0]        mag_s1_reg [4];
    logic                      neg_s1_reg [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            coord[k]    = s_axis_tdata[k*COORD_W +: COORD_W];
            mag_next[k] = coord[k][COORD_W-1] ? COORD_W'(0) - coord[k] : coord[k];
        end
        // latitudes are items 0 and 2, longitudes 1 and 3
        err_in = (32'(mag_next[0]) > LAT_LIM) || (32'(mag_next[2]) > LAT_LIM)
              || (32'(mag_next[1]) > LON_LIM) || (32'(mag_next[3]) > LON_LIM);
    end

    // ---------------------------------------------------------------
    // s2..s4: degrees to binary angle, |v| split as 90 * quo + rem
    // ---------------------------------------------------------------
    logic [50:0]         prod90 [4];
    logic [QUOT_W-1:0]   quo_s2_reg [4];
    logic [COORD_W-1:0]  mag_s2_reg [4];
    logic                neg_s2_reg [4];
    logic [COORD_W-1:0]  rem_full [4];
    logic [QUOT_W-1:0]   quo_s3_reg [4];
    logic [6:0]          rem_s3_reg [4];
    logic                neg_s3_reg [4];
    turn_t               tmag [4];
    turn_t               turn_s4_reg [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod90[k]   = 51'(mag_s1_reg[k]) * 51'(RECIP_90);
            rem_full[k] = mag_s2_reg[k] - COORD_W'(COORD_W'(quo_s2_reg[k]) * COORD_W'(90));
            tmag[k]     = (turn_t'(quo_s3_reg[k]) << TURN_SHIFT) + FRAC_TBL[rem_s3_reg[k]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                mag_s1_reg[k]  <= mag_next[k];
                neg_s1_reg[k]  <= coord[k][COORD_W-1];
                quo_s2_reg[k]  <= prod90[k][50:32];
                mag_s2_reg[k]  <= mag_s1_reg[k];
                neg_s2_reg[k]  <= neg_s1_reg[k];
                quo_s3_reg[k]  <= quo_s2_reg[k];
                rem_s3_reg[k]  <= rem_full[k][6:0];
                neg_s3_reg[k]  <= neg_s2_reg[k];
                turn_s4_reg[k] <= neg_s3_reg[k] ? turn_t'(0) - tmag[k] : tmag[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // s5: the five cordic angles
    // ---------------------------------------------------------------
    turn_t dlat;
    turn_t dlon;
    turn_t p1_reg, p2_reg, dl_reg, hp_reg, hl_reg;

    assign dlat = turn_s4_reg[2] - turn_s4_reg[0];
    assign dlon = turn_s4_reg[3] - turn_s4_reg[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= turn_s4_reg[0];
            p2_reg <= turn_s4_reg[2];
            dl_reg <= dlon;
            hp_reg <= {dlat[31], dlat[31:1]};   // signed half angle
            hl_reg <= {dlon[31], dlon[31:1]};
        end
    end

    // ---------------------------------------------------------------
    // sine/cosine cordic, five in parallel
    // ---------------------------------------------------------------
    q30_t sp1, cp1, sp2, cp2, sdl, cdl, shp, shl;

    gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_p1 (
        .clk(clk), .en(adv), .angle(p1_reg), .sin_val(sp1), .cos_val(cp1));
    gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_p2 (
        .clk(clk), .en(adv), .angle(p2_reg), .sin_val(sp2), .cos_val(cp2));
    gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dl (
        .clk(clk), .en(adv), .angle(dl_reg), .sin_val(sdl), .cos_val(cdl));
    gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_hp (
        .clk(clk), .en(adv), .angle(hp_reg), .sin_val(shp), .cos_val());
    gcdb_sincos #(.STAGES(CORDIC_STAGES)) u_sc_hl (
        .clk(clk), .en(adv), .angle(hl_reg), .sin_val(shl), .cos_val());

    // ---------------------------------------------------------------
    // h1..h3: haversine term and bearing vector
    // ---------------------------------------------------------------
    q30_t hp2_reg, cc_reg, hl2_reg, yb_reg, tt_reg, cs_reg, cdl_h1_reg;
    q30_t hb_reg, td_reg, hp2_h2_reg, yb_h2_reg, cs_h2_reg;
    logic [30:0]        h_reg;
    logic signed [32:0] xb_reg;
    q30_t               yb_h3_reg;

    logic signed [32:0] hsum;
    logic [30:0]        h_next;

    always_comb
    begin
        hsum = 33'(hp2_h2_reg) + 33'(hb_reg);
        if (hsum[32])
        begin
            h_next = '0;
        end
        else if (hsum > 33'sd1073741824)
        begin
            h_next = QUARTER_TURN;   // q30 one
        end
        else
        begin
            h_next = hsum[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hp2_reg    <= mul_q30(shp, shp);
            cc_reg     <= mul_q30(cp1, cp2);
            hl2_reg    <= mul_q30(shl, shl);
            yb_reg     <= mul_q30(sdl, cp2);
            tt_reg     <= mul_q30(sp1, cp2);
            cs_reg     <= mul_q30(cp1, sp2);
            cdl_h1_reg <= cdl;

            hb_reg     <= mul_q30(cc_reg, hl2_reg);
            td_reg     <= mul_q30(tt_reg, cdl_h1_reg);
            hp2_h2_reg <= hp2_reg;
            yb_h2_reg  <= yb_reg;
            cs_h2_reg  <= cs_reg;

            h_reg      <= h_next;
            xb_reg     <= 33'(cs_h2_reg) - 33'(td_reg);
            yb_h3_reg  <= yb_h2_reg;
        end
    end

    // ---------------------------------------------------------------
    // square roots of h and 1 - h, one root bit per stage
    // ---------------------------------------------------------------
    logic [63:0] sq_in [2];
    logic [63:0] sq_v_reg [2][SQRT_STAGES];
    logic [63:0] sq_r_reg [2][SQRT_STAGES];

    assign sq_in[0] = {3'b0, h_reg, 30'b0};
    assign sq_in[1] = {3'b0, QUARTER_TURN - h_reg, 30'b0};

    for (genvar k = 0; k < 2; k++)
    begin : g_sqrt
        for (genvar i = 0; i < SQRT_STAGES; i++)
        begin : g_step
            localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
            logic [63:0] v_src;
            logic [63:0] r_src;
            logic [63:0] trial;

            if (i == 0)
            begin : g_first
                assign v_src = sq_in[k];
                assign r_src = '0;
            end
            else
            begin : g_rest
                assign v_src = sq_v_reg[k][i-1];
                assign r_src = sq_r_reg[k][i-1];
            end

            assign trial = r_src + BIT;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (v_src >= trial)
                    begin
                        sq_v_reg[k][i] <= v_src - trial;
                        sq_r_reg[k][i] <= (r_src >> 1) + BIT;
                    end
                    else
                    begin
                        sq_v_reg[k][i] <= v_src;
                        sq_r_reg[k][i] <= r_src >> 1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // vectoring cordic: central half angle and bearing angle
    // ---------------------------------------------------------------
    logic signed [VEC_IN_W-1:0] cy_in, cx_in, by_in, bx_in;
    turn_t                      dist_turns;
    turn_t                      brg_turns;
    turn_t                      brg_dly_reg [SQRT_STAGES];

    assign cy_in = $signed({3'b0, sq_r_reg[0][SQRT_STAGES-1][30:0]});
    assign cx_in = $signed({3'b0, sq_r_reg[1][SQRT_STAGES-1][30:0]});
    assign by_in = VEC_IN_W'(yb_h3_reg);
    assign bx_in = VEC_IN_W'(xb_reg);

    gcdb_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(VEC_IN_W)) u_at_dist (
        .clk(clk), .en(adv), .y_in(cy_in), .x_in(cx_in), .turns(dist_turns));

    // bearing starts alongside the square roots and waits out their depth
    gcdb_atan2 #(.STAGES(CORDIC_STAGES), .IN_W(VEC_IN_W)) u_at_brg (
        .clk(clk), .en(adv), .y_in(by_in), .x_in(bx_in), .turns(brg_turns));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            brg_dly_reg[0] <= brg_turns;
            for (int i = 1; i < SQRT_STAGES; i++)
            begin
                brg_dly_reg[i] <= brg_dly_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // f1: clamp and scale; out: rounding, wrap, error override
    // ---------------------------------------------------------------
    logic [30:0]  zc;
    logic [59:0]  dprod_reg;
    logic [63:0]  bprod_reg;
    logic [59:0]  dsum;
    logic [63:0]  bsum;
    logic [31:0]  brg_round;
    logic [DIST_W-1:0] dist_out_reg;
    logic [BRG_W-1:0]  brg_out_reg;

    always_comb
    begin
        if (dist_turns[31])
        begin
            zc = '0;
        end
        else if (dist_turns[30:0] > QUARTER_TURN)
        begin
            zc = QUARTER_TURN;
        end
        else
        begin
            zc = dist_turns[30:0];
        end
        dsum      = dprod_reg + (60'(1) << 39);
        bsum      = bprod_reg + (64'(1) << 31);
        brg_round = bsum[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dprod_reg <= 60'(zc) * 60'(DIST_SCALE);
            bprod_reg <= 64'(brg_dly_reg[SQRT_STAGES-1]) * 64'(FULL_DEG);
            if (err_reg[LAT-2])
            begin
                dist_out_reg <= '0;
                brg_out_reg  <= '0;
            end
            else
            begin
                dist_out_reg <= dsum[58:40];
                // a bearing that rounds up to a full circle wraps to zero
                brg_out_reg  <= (brg_round >= FULL_DEG) ? '0 : brg_round[BRG_W-1:0];
            end
        end
    end

    assign m_axis_tdata = {4'b0, brg_out_reg, dist_out_reg};
    assign m_axis_tuser = err_reg[LAT-1];

endmodule

### verif/testbench.sv
// testbench for great_circle_distance_bearing_core: directed and random point
// pairs checked against an in-bench fixed-point haversine and bearing predictor.
// depends on gcdb_pkg and the core rtl.
`timescale 1ns / 1ps

module testbench;
    import gcdb_pkg::*;

    // one predicted output item
    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [BRG_W-1:0]  brg;
        logic              err;
    } leg_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    leg_t expected_legs [$];
    int   errors = 0;
    int   snd_idle = 0;
    int   rcv_idle = 0;

    localparam int LAT_MAX = 90 << ANGLE_FRAC_BITS;
    localparam int LON_MAX = 180 << ANGLE_FRAC_BITS;
    localparam int NSTG = CORDIC_STAGES_DEF > 32 ? 32 : CORDIC_STAGES_DEF;

    great_circle_distance_bearing_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic longint signed32(input logic [31:0] u);
        return longint'(u) - (u[31] ? (longint'(1) <<< 32) : 0);
    endfunction

    // rounded degrees to binary angle, sign applied after rounding
    function automatic logic [31:0] deg_turns(input longint v);
        longint unsigned m;
        longint unsigned d;
        logic [31:0]     r;
        m = v < 0 ? longint'(-v) : longint'(v);
        d = longint'(360) << ANGLE_FRAC_BITS;
        r = 32'(((m << 32) + d / 2) / d);
        return v < 0 ? 32'(0) - r : r;
    endfunction

    function automatic void rot_sin_cos(input logic [31:0] ang, output longint s,
                                        output longint c);
        logic   flip;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        x = longint'(CORDIC_GAIN);
        y = 0;
        if (flip)
            ang = ang + HALF_TURN;
        z = signed32(ang);
        for (int i = 0; i < NSTG; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + longint'(ATAN_TURNS[i]);
            end
            x = nx; y = ny;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // vectoring atan2, zero y counts as non-negative
    function automatic logic [31:0] vec_atan2(input longint y, input longint x);
        logic [31:0] z;
        longint      nx;
        longint      ny;
        z = '0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            x = -x; y = -y; z = HALF_TURN;
        end
        for (int i = 0; i < NSTG; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TURNS[i];
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TURNS[i];
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic leg_t predict_leg(input logic signed [24:0] lat1,
                                         input logic signed [24:0] lon1,
                                         input logic signed [24:0] lat2,
                                         input logic signed [24:0] lon2);
        leg_t            res;
        logic [31:0]     p1;
        logic [31:0]     p2;
        logic [31:0]     dl;
        logic [31:0]     bt;
        longint          sp1, cp1, sp2, cp2, sdl, cdl, shp, chp, shl, chl;
        longint          h, zc, x, y, t;
        longint unsigned sy, sx, dist_q, brg, full;
        res = '{distance: '0, brg: '0, err: 1'b0};
        // strict limits, exactly 90 or 180 is still a valid coordinate
        if (lat1 > LAT_MAX || -lat1 > LAT_MAX || lat2 > LAT_MAX || -lat2 > LAT_MAX ||
            lon1 > LON_MAX || -lon1 > LON_MAX || lon2 > LON_MAX || -lon2 > LON_MAX)
        begin
            res.err = 1'b1;
            return res;
        end
        p1 = deg_turns(lat1);
        p2 = deg_turns(lat2);
        dl = deg_turns(lon2) - deg_turns(lon1);
        rot_sin_cos(p1, sp1, cp1);
        rot_sin_cos(p2, sp2, cp2);
        rot_sin_cos(dl, sdl, cdl);
        rot_sin_cos(32'(signed32(p2 - p1) >>> 1), shp, chp);
        rot_sin_cos(32'(signed32(dl) >>> 1), shl, chl);
        // haversine term clamped to [0, 1]
        h = ((shp * shp) >>> 30) + ((((cp1 * cp2) >>> 30) * ((shl * shl) >>> 30)) >>> 30);
        if (h < 0)
            h = 0;
        if (h > (longint'(1) <<< 30))
            h = longint'(1) <<< 30;
        sy = int_sqrt(longint'(h) << 30);
        sx = int_sqrt(longint'((longint'(1) <<< 30) - h) << 30);
        zc = signed32(vec_atan2(longint'(sy), longint'(sx)));
        if (zc < 0)
            zc = 0;
        if (zc > (longint'(1) <<< 30))
            zc = longint'(1) <<< 30;
        dist_q = (longint'(zc) * longint'(DIST_SCALE) + (longint'(1) << 39)) >> 40;
        // initial bearing
        y = (sdl * cp2) >>> 30;
        t = (sp1 * cp2) >>> 30;
        x = ((cp1 * sp2) >>> 30) - ((t * cdl) >>> 30);
        bt = vec_atan2(y, x);
        full = longint'(360) << ANGLE_FRAC_BITS;
        brg = (longint'(bt) * full + (longint'(1) << 31)) >> 32;
        if (brg >= full)
            brg = 0;
        res.distance = dist_q[DIST_W-1:0];
        res.brg      = brg[BRG_W-1:0];
        return res;
    endfunction

    // ---------------- driving ----------------

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);

    task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2);
        @(negedge clk);
        if ($urandom_range(0, 99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, 25'(lon2), 25'(lat2), 25'(lon1), 25'(lat1)};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_legs.insert(expected_legs.size(),
                             predict_leg(25'(lat1), 25'(lon1), 25'(lat2), 25'(lon2)));
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_legs.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- checking ----------------

    always @(posedge clk)
    begin
        leg_t exp_leg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_legs.size() == 0)
            begin
                $error("unexpected output item");
                errors++;
            end
            else
            begin
                exp_leg = expected_legs.pop_front();
                if (m_axis_tdata[DIST_W-1:0] !== exp_leg.distance)
                begin
                    $error("distance_sixteenth_km expected %0d got %0d",
                           exp_leg.distance, m_axis_tdata[DIST_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[DIST_W+BRG_W-1:DIST_W] !== exp_leg.brg)
                begin
                    $error("bearing expected %0d got %0d",
                           exp_leg.brg, m_axis_tdata[DIST_W+BRG_W-1:DIST_W]);
                    errors++;
                end
                if (m_axis_tuser !== exp_leg.err)
                begin
                    $error("coord_error expected %0b got %0b", exp_leg.err, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // extremes, range limits, same point, poles, antipodes
    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(LAT_MAX, 12345, 10 << 16, 20 << 16);
        send_pair(-LAT_MAX, 0, 0, 0);
        send_pair(45 << 16, 45 << 16, 45 << 16, 45 << 16);
        send_pair(30 << 16, 10 << 16, -(30 << 16), -(170 << 16));
        send_pair(LAT_MAX + 1, 0, 0, 0);
        send_pair(0, 0, -LAT_MAX - 1, 0);
        send_pair(0, LON_MAX + 1, 0, 0);
        send_pair(0, 0, 0, -LON_MAX - 1);
        send_pair(16777215, 16777215, 16777215, 16777215);
        send_pair(-16777215, -16777215, -16777215, -16777215);
        send_pair(1, -1, -1, 1);
        send_pair(51 << 16, 0, 40 << 16, -(74 << 16));
        send_pair(0, 0, 1, 0);
        send_pair(-(33 << 16), 151 << 16, 35 << 16, 139 << 16);
        end_burst();
    endtask

    function automatic int rand_coord(input int lim);
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(0, 33554430)) - 16777215;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? lim : -lim;
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic test_random(input int s_pct, input int r_pct, input int count);
        snd_idle = s_pct;
        rcv_idle = r_pct;
        repeat (count)
            send_pair(rand_coord(LAT_MAX), rand_coord(LON_MAX),
                      rand_coord(LAT_MAX), rand_coord(LON_MAX));
        end_burst();
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        // hold the sender off until the pipeline has emptied
        wait_drained();
        test_random(29, 82, 150);
        test_random(82, 29, 150);
        test_random(0, 0, 150);
        rcv_idle = 0;
        wait_drained();
        repeat (120)
            @(posedge clk);
        if (expected_legs.size() != 0)
            errors++;
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
